[sv/rea_pkg.sv]
`default_nettype none
package rea_pkg;

    localparam int FRAC_BITS = 16;
    localparam int T_W       = FRAC_BITS + 1;
    localparam int RAD_OUT_W = 48;
    localparam int MUL_W     = 34;
    localparam int SQ_W      = 66;
    localparam int ROOT_W    = 34;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 1'b1;

    localparam logic [15:0]        CUTOFF_RST = 16'd655;
    localparam logic [T_W-1:0]     T_ONE      = T_W'(1) << FRAC_BITS;
    localparam logic [32:0]        LOG2E_Q32  = 33'd6196328019;
    localparam logic [RAD_OUT_W-1:0] RAD_MAX  = '1;

    typedef logic [31:0] t_rtab [0:31];

    function automatic logic [31:0] f_isqrt64(input logic [63:0] n);
        logic [31:0] r;
        logic [31:0] c;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            c = r | (32'd1 << b);
            if ((64'(c) * 64'(c)) <= n) begin
                r = c;
            end
        end
        return r;
    endfunction

    // r_k = 2^(-2^-(k+1)) in Q32, each from the root of the one before
    function automatic t_rtab f_rtab();
        t_rtab       tab;
        logic [31:0] r;
        r = f_isqrt64(64'h8000_0000_0000_0000);
        for (int k = 0; k < 32; k++) begin
            tab[k] = r;
            r = f_isqrt64({r, 32'd0});
        end
        return tab;
    endfunction

    localparam t_rtab R_TAB = f_rtab();

endpackage
`default_nettype wire

[sv/rea_mul.sv]
`default_nettype none
module rea_mul (
    input  wire logic                          i_clk,
    input  wire logic [rea_pkg::MUL_W-1:0]     i_a,
    input  wire logic [rea_pkg::MUL_W-1:0]     i_b,
    output logic      [2*rea_pkg::MUL_W-1:0]   o_prod
);
    import rea_pkg::*;

    logic [2*MUL_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

[sv/rea_sqrt.sv]
`default_nettype none
module rea_sqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [rea_pkg::SQ_W-1:0]    i_radicand,
    output logic      [rea_pkg::ROOT_W-1:0]  o_root,
    output logic                             o_done
);
    import rea_pkg::*;

    localparam int PAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(ROOT_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [REM_W-1:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [PAD_W-1:0] r_rad;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    assign rem_sh = {r_rem[ROOT_W-1:0], r_rad[PAD_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_root <= '0;
                r_rad  <= PAD_W'(i_radicand);
            end else if (r_busy) begin
                // one result bit per cycle, restoring form
                r_rad <= r_rad << 2;
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[ROOT_W-2:0], 1'b0};
                end
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule
`default_nettype wire

[sv/ray_emission_absorption_accumulator_unit.sv]
`default_nettype none
// Emission/absorption integral along a ray path. Points enter one item at a time;
// from the second point on, the segment length (integer square root of the squared
// distance) weights the previous absorption into the saturating Q32.16 radiance, and
// the previous extinction attenuates the Q1.16 transmittance, exponentially
// (mode 0) or linearly with a cutoff stop (mode 1). A last-point item produces one
// result and clears the ray. All products go through one registered 34x34
// multiplier; the root comes from a bit-per-cycle unit. A new item is taken only
// once the previous one is through: soonest when nothing is accumulated (first
// point or stopped ray), later in linear mode and longest in exponential mode,
// where the 32-step 2^-f product dominates (each step issues a product, then takes
// it); an exponential segment whose exponent reaches 64 skips that product. A
// last-point item also waits while the previous result has not been taken.
// Configuration writes are taken only while the block is idle, between items.
module ray_emission_absorption_accumulator_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [31:0]                i_point_x,
    input  wire logic signed [31:0]                i_point_y,
    input  wire logic signed [31:0]                i_point_z,
    input  wire logic [23:0]                       i_absorb_value,
    input  wire logic [23:0]                       i_emit_value,
    input  wire logic                              i_last_point,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [rea_pkg::RAD_OUT_W-1:0]          o_radiance,
    output logic                                   o_terminated_early,
    output logic                                   o_saturated,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [rea_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [rea_pkg::CFG_DAT_W-1:0]     i_cfg_data
);
    import rea_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b0000000001,
        ST_SQ      = 10'b0000000010,
        ST_ROOT_GO = 10'b0000000100,
        ST_ROOT    = 10'b0000001000,
        ST_AL      = 10'b0000010000,
        ST_LIN     = 10'b0000100000,
        ST_EXP     = 10'b0001000000,
        ST_EXPM    = 10'b0010000000,
        ST_EXPT    = 10'b0100000000,
        ST_DONE    = 10'b1000000000
    } t_state;

    t_state r_state;
    logic [2:0]  r_cnt;
    logic [4:0]  r_bit;
    logic        r_ph;
    logic        r_mode;
    logic [15:0] r_cutoff;

    logic signed [31:0] r_cx, r_cy, r_cz, r_px, r_py, r_pz;
    logic [23:0] r_cab, r_cem, r_pab, r_pem;
    logic        r_clast;
    logic        r_have, r_stop, r_clip;
    logic [RAD_OUT_W-1:0] r_rad;
    logic [T_W-1:0]  r_t;
    logic [SQ_W-1:0] r_sq;
    logic [32:0] r_len;
    logic [56:0] r_al;
    logic [40:0] r_d;
    logic [50:0] r_plo;
    logic [41:0] r_inc;
    logic [6:0]  r_n;
    logic [31:0] r_f;
    logic [32:0] r_acc;

    logic                 r_ovalid;
    logic [RAD_OUT_W-1:0] r_orad;
    logic                 r_oterm, r_osat;

    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [2*MUL_W-1:0] prod;
    logic               sq_start, sq_done;
    logic [ROOT_W-1:0]  sq_root;

    logic signed [32:0] dxs, dys, dzs;
    logic [32:0] dx, dy, dz;
    logic [73:0] p_full;
    logic [48:0] sum49;
    logic [T_W-1:0] t_lin;
    logic [49:0] t_shift;
    logic out_free;
    logic out_load;

    assign dxs = {r_cx[31], r_cx} - {r_px[31], r_px};
    assign dys = {r_cy[31], r_cy} - {r_py[31], r_py};
    assign dzs = {r_cz[31], r_cz} - {r_pz[31], r_pz};
    assign dx  = dxs[32] ? 33'(-dxs) : 33'(dxs);
    assign dy  = dys[32] ? 33'(-dys) : 33'(dys);
    assign dz  = dzs[32] ? 33'(-dzs) : 33'(dzs);

    assign p_full  = {23'd0, r_plo} + {prod[39:0], 34'd0};
    assign sum49   = {1'b0, r_rad} + 49'(r_inc);
    assign t_lin   = (r_d >= 41'(T_ONE)) ? '0 : prod[32:16];
    assign t_shift = prod[49:0] >> 32;
    assign out_free = !r_ovalid || i_ready;
    assign out_load = (r_state == ST_DONE) && r_clast && out_free;
    assign sq_start = (r_state == ST_ROOT_GO);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_SQ: begin
                unique case (r_cnt)
                    3'd0:    begin mul_a = MUL_W'(dx); mul_b = MUL_W'(dx); end
                    3'd1:    begin mul_a = MUL_W'(dy); mul_b = MUL_W'(dy); end
                    3'd2:    begin mul_a = MUL_W'(dz); mul_b = MUL_W'(dz); end
                    default: ;
                endcase
            end
            ST_AL: begin
                unique case (r_cnt)
                    3'd0:    begin mul_a = MUL_W'(r_pab); mul_b = MUL_W'(r_len); end
                    3'd1:    begin mul_a = MUL_W'(r_pem); mul_b = MUL_W'(r_len); end
                    3'd2:    begin mul_a = r_al[33:0]; mul_b = MUL_W'(r_t); end
                    3'd3:    begin mul_a = MUL_W'(r_al[56:34]); mul_b = MUL_W'(r_t); end
                    default: ;
                endcase
            end
            ST_LIN: begin
                mul_a = MUL_W'(r_t);
                mul_b = MUL_W'(T_ONE - r_d[T_W-1:0]);
            end
            ST_EXP: begin
                mul_a = MUL_W'(r_d[21:0]);
                mul_b = MUL_W'(LOG2E_Q32);
            end
            ST_EXPM: begin
                mul_a = MUL_W'(r_acc);
                mul_b = MUL_W'(R_TAB[r_bit]);
            end
            ST_EXPT: begin
                mul_a = MUL_W'(r_t);
                mul_b = MUL_W'(r_acc);
            end
            default: ;
        endcase
    end

    rea_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    rea_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (r_sq),
        .o_root     (sq_root),
        .o_done     (sq_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_bit    <= '0;
            r_ph     <= 1'b0;
            r_mode   <= 1'b0;
            r_cutoff <= CUTOFF_RST;
            r_px     <= '0;
            r_py     <= '0;
            r_pz     <= '0;
            r_pab    <= '0;
            r_pem    <= '0;
            r_have   <= 1'b0;
            r_stop   <= 1'b0;
            r_clip   <= 1'b0;
            r_rad    <= '0;
            r_t      <= T_ONE;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_MODE:   r_mode   <= i_cfg_data[0];
                    CFG_CUTOFF: r_cutoff <= i_cfg_data;
                    default:    ;
                endcase
            end

            if (r_ovalid && i_ready && !out_load) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_cx    <= i_point_x;
                        r_cy    <= i_point_y;
                        r_cz    <= i_point_z;
                        r_cab   <= i_absorb_value;
                        r_cem   <= i_emit_value;
                        r_clast <= i_last_point;
                        r_cnt   <= '0;
                        r_sq    <= '0;
                        r_state <= (r_have && !r_stop) ? ST_SQ : ST_DONE;
                    end
                end
                ST_SQ: begin
                    if (r_cnt != 3'd0) begin
                        r_sq <= r_sq + prod[SQ_W-1:0];
                    end
                    if (r_cnt == 3'd3) begin
                        r_state <= ST_ROOT_GO;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                ST_ROOT_GO: r_state <= ST_ROOT;
                ST_ROOT: begin
                    if (sq_done) begin
                        r_len   <= sq_root[32:0];
                        r_cnt   <= '0;
                        r_state <= ST_AL;
                    end
                end
                ST_AL: begin
                    unique case (r_cnt)
                        3'd1: r_al  <= prod[56:0];
                        3'd2: r_d   <= prod[56:16];
                        3'd3: r_plo <= prod[50:0];
                        3'd4: r_inc <= p_full[73:32];
                        3'd5: begin
                            if (sum49 > 49'(RAD_MAX)) begin
                                r_rad  <= RAD_MAX;
                                r_clip <= 1'b1;
                            end else begin
                                r_rad <= sum49[RAD_OUT_W-1:0];
                            end
                            r_state <= r_mode ? ST_LIN : ST_EXP;
                        end
                        default: ;
                    endcase
                    r_cnt <= (r_cnt == 3'd5) ? 3'd0 : r_cnt + 1'b1;
                end
                ST_LIN: begin
                    if (r_cnt == 3'd1) begin
                        r_t <= t_lin;
                        if (t_lin < T_W'(r_cutoff)) begin
                            r_stop <= 1'b1;
                        end
                        r_state <= ST_DONE;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                ST_EXP: begin
                    if (r_cnt == 3'd0 && r_d >= (41'd64 << FRAC_BITS)) begin
                        r_t     <= '0;
                        r_state <= ST_DONE;
                    end else if (r_cnt == 3'd1) begin
                        r_n     <= prod[54:48];
                        r_f     <= prod[47:16];
                        r_acc   <= 33'h1_0000_0000;
                        r_bit   <= '0;
                        r_ph    <= 1'b0;
                        r_state <= ST_EXPM;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                ST_EXPM: begin
                    // issue on phase 0, take the product on phase 1
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        if (r_f[~r_bit]) begin
                            r_acc <= prod[64:32];
                        end
                        if (r_bit == 5'd31) begin
                            r_cnt   <= '0;
                            r_state <= ST_EXPT;
                        end
                        r_bit <= r_bit + 1'b1;
                    end
                end
                ST_EXPT: begin
                    if (r_cnt == 3'd1) begin
                        r_t     <= (r_n >= 7'd32) ? '0 : T_W'(t_shift >> r_n[4:0]);
                        r_state <= ST_DONE;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                ST_DONE: begin
                    if (r_clast) begin
                        if (out_free) begin
                            r_ovalid <= 1'b1;
                            r_orad   <= r_rad;
                            r_oterm  <= r_stop;
                            r_osat   <= r_clip;
                            r_px     <= '0;
                            r_py     <= '0;
                            r_pz     <= '0;
                            r_pab    <= '0;
                            r_pem    <= '0;
                            r_have   <= 1'b0;
                            r_stop   <= 1'b0;
                            r_clip   <= 1'b0;
                            r_rad    <= '0;
                            r_t      <= T_ONE;
                            r_state  <= ST_IDLE;
                        end
                    end else begin
                        r_px    <= r_cx;
                        r_py    <= r_cy;
                        r_pz    <= r_cz;
                        r_pab   <= r_cab;
                        r_pem   <= r_cem;
                        r_have  <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_ready            = (r_state == ST_IDLE);
    assign o_valid            = r_ovalid;
    assign o_radiance         = r_orad;
    assign o_terminated_early = r_oterm;
    assign o_saturated        = r_osat;
    assign o_cfg_ready        = (r_state == ST_IDLE);

endmodule
`default_nettype wire

[bench/radiance_checker.sv]
`timescale 1ns / 100ps
module radiance_checker
    import rea_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic                     o_ready,
    input  logic signed [31:0]       i_point_x,
    input  logic signed [31:0]       i_point_y,
    input  logic signed [31:0]       i_point_z,
    input  logic [23:0]              i_absorb_value,
    input  logic [23:0]              i_emit_value,
    input  logic                     i_last_point,
    input  logic                     o_valid,
    input  logic                     i_ready,
    input  logic [RAD_OUT_W-1:0]     o_radiance,
    input  logic                     o_terminated_early,
    input  logic                     o_saturated,
    input  logic                     i_cfg_valid,
    input  logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DAT_W-1:0]     i_cfg_data,
    output int                       fail_count,
    output int                       pending
);

    typedef struct packed {
        logic [47:0] rad;
        logic        term;
        logic        sat;
    } t_ray_result;

    localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [16:0] UNITY   = 17'h10000;

    t_ray_result       radiance_q [$];
    logic [31:0]       decay_tab [0:31];

    logic signed [31:0] prev_x, prev_y, prev_z;
    logic [23:0]        prev_absorb, prev_emit;
    logic [47:0]        rad_sum;
    logic [16:0]        trans;
    logic               have_prev, halted, clip;
    logic               lin_mode;
    logic [15:0]        cutoff;

    function automatic logic [31:0] root32(input logic [63:0] n);
        logic [31:0]  r;
        logic [31:0]  c;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            c = r | (32'd1 << b);
            if (64'(c) * 64'(c) <= n) begin
                r = c;
            end
        end
        return r;
    endfunction

    function automatic logic [34:0] seg_length(input logic [65:0] n);
        logic [34:0] r;
        logic [34:0] c;
        r = '0;
        for (int b = 34; b >= 0; b--) begin
            c = r | (35'd1 << b);
            if (70'(c) * 70'(c) <= 70'(n)) begin
                r = c;
            end
        end
        return r;
    endfunction

    // t * exp(-e), e in Q.16, via 2^-(e*log2(e)) split into integer and fraction
    function automatic logic [16:0] exp_decay(input logic [16:0] t, input logic [63:0] e);
        logic [63:0] y;
        logic [63:0] acc;
        logic [31:0] whole;
        logic [31:0] frac;
        if (e >= (64'd64 << 16)) begin
            return '0;
        end
        y = (e * 64'd6196328019) >> 16;
        whole = y[63:32];
        frac = y[31:0];
        acc = 64'd1 << 32;
        for (int k = 1; k <= 32; k++) begin
            if (frac[32-k]) begin
                acc = (acc * 64'(decay_tab[k-1])) >> 32;
            end
        end
        if (whole >= 32) begin
            return '0;
        end
        return 17'((64'(t) * acc) >> (32 + whole));
    endfunction

    task automatic clear_ray();
        prev_x = '0;
        prev_y = '0;
        prev_z = '0;
        prev_absorb = '0;
        prev_emit = '0;
        rad_sum = '0;
        trans = UNITY;
        have_prev = 1'b0;
        halted = 1'b0;
        clip = 1'b0;
    endtask

    task automatic accept_point();
        logic [32:0]  dx, dy, dz;
        logic [65:0]  sq;
        logic [34:0]  len;
        logic [127:0] prod;
        logic [127:0] inc;
        logic [63:0]  d;
        t_ray_result  res;
        if (have_prev && !halted) begin
            dx = 33'($signed({i_point_x[31], i_point_x}) - $signed({prev_x[31], prev_x}));
            if (dx[32]) dx = -dx;
            dy = 33'($signed({i_point_y[31], i_point_y}) - $signed({prev_y[31], prev_y}));
            if (dy[32]) dy = -dy;
            dz = 33'($signed({i_point_z[31], i_point_z}) - $signed({prev_z[31], prev_z}));
            if (dz[32]) dz = -dz;
            sq = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy) + 66'(dz) * 66'(dz);
            len = seg_length(sq);
            prod = 128'(prev_absorb) * 128'(len) * 128'(trans);
            inc = prod >> 32;
            if (inc > 128'(SUM_MAX) || 128'(rad_sum) + inc > 128'(SUM_MAX)) begin
                rad_sum = SUM_MAX;
                clip = 1'b1;
            end else begin
                rad_sum = rad_sum + inc[47:0];
            end
            d = (64'(prev_emit) * 64'(len)) >> 16;
            if (!lin_mode) begin
                trans = exp_decay(trans, d);
            end else begin
                if (d >= 64'(UNITY)) begin
                    trans = '0;
                end else begin
                    trans = 17'((64'(trans) * (64'(UNITY) - d)) >> 16);
                end
                if (trans < 17'(cutoff)) begin
                    halted = 1'b1;
                end
            end
        end
        prev_x = i_point_x;
        prev_y = i_point_y;
        prev_z = i_point_z;
        prev_absorb = i_absorb_value;
        prev_emit = i_emit_value;
        have_prev = 1'b1;
        if (i_last_point) begin
            res.rad = rad_sum;
            res.term = halted;
            res.sat = clip;
            radiance_q = {radiance_q, res};
            clear_ray();
        end
    endtask

    initial begin
        logic [31:0] r;
        fail_count = 0;
        pending = 0;
        r = root32(64'h8000_0000_0000_0000);
        for (int k = 0; k < 32; k++) begin
            decay_tab[k] = r;
            r = root32({r, 32'd0});
        end
        clear_ray();
        lin_mode = 1'b0;
        cutoff = 16'd655;
    end

    always @(posedge i_clk) begin
        t_ray_result want;
        if (!i_rst_n) begin
            clear_ray();
            lin_mode = 1'b0;
            cutoff = 16'd655;
            radiance_q.delete();
        end else begin
            if (o_valid && i_ready) begin
                if (radiance_q.size() == 0) begin
                    $display("%0t: unexpected result rad=%h term=%b sat=%b", $time,
                             o_radiance, o_terminated_early, o_saturated);
                    fail_count++;
                end else begin
                    want = radiance_q.pop_front();
                    if (o_radiance !== want.rad) begin
                        $display("%0t: radiance expected %h actual %h", $time,
                                 want.rad, o_radiance);
                        fail_count++;
                    end
                    if (o_terminated_early !== want.term) begin
                        $display("%0t: terminated_early expected %b actual %b", $time,
                                 want.term, o_terminated_early);
                        fail_count++;
                    end
                    if (o_saturated !== want.sat) begin
                        $display("%0t: saturated expected %b actual %b", $time,
                                 want.sat, o_saturated);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_MODE) begin
                    lin_mode = i_cfg_data[0];
                end else if (i_cfg_index == CFG_CUTOFF) begin
                    cutoff = i_cfg_data;
                end
            end
            if (i_valid && o_ready) begin
                accept_point();
            end
        end
        pending = radiance_q.size();
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
module tb;
    import rea_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic signed [31:0]    i_point_x, i_point_y, i_point_z;
    logic [23:0]           i_absorb_value, i_emit_value;
    logic                  i_last_point;
    logic                  o_valid;
    logic                  i_ready;
    logic [RAD_OUT_W-1:0]  o_radiance;
    logic                  o_terminated_early, o_saturated;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DAT_W-1:0]  i_cfg_data;
    int                    fail_count;
    int                    pending;

    bit                    idle_on;
    bit                    hold_req;
    logic signed [31:0]    cur_x, cur_y, cur_z;

    ray_emission_absorption_accumulator_unit u_dut (.*);

    radiance_checker u_chk (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #60_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: random stalls, plus one long hold on request
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready = 1'b0;
                repeat (400) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                i_ready = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end
            i_ready = 1'b1;
        end
    end

    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic [23:0] ab,
                              input logic [23:0] em, input logic last);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_point_x = x;
        i_point_y = y;
        i_point_z = z;
        i_absorb_value = ab;
        i_emit_value = em;
        i_last_point = last;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_index = idx;
        i_cfg_data = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // hold until every result is in, then let a trailing item finish
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    task automatic send_ray(input int npts, input bit wide);
        logic [23:0] ab, em;
        cur_x = $urandom;
        cur_y = $urandom;
        cur_z = $urandom;
        for (int i = 0; i < npts; i++) begin
            if (i > 0) begin
                if (wide) begin
                    cur_x = $urandom;
                    cur_y = $urandom;
                    cur_z = $urandom;
                end else begin
                    cur_x = cur_x + ($signed($urandom_range(0, 1 << 18)) - (1 << 17));
                    cur_y = cur_y + ($signed($urandom_range(0, 1 << 18)) - (1 << 17));
                    cur_z = cur_z + ($signed($urandom_range(0, 1 << 18)) - (1 << 17));
                end
            end
            ab = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 20'hFFFFF));
            em = ($urandom_range(0, 4) == 0) ? 24'($urandom) : 24'($urandom_range(0, 16'h7FFF));
            send_point(cur_x, cur_y, cur_z, ab, em, i == npts - 1);
        end
    endtask

    task automatic run_rays(input int items);
        int sent;
        int n;
        sent = 0;
        while (sent < items) begin
            n = $urandom_range(1, 8);
            send_ray(n, $urandom_range(0, 9) == 0);
            sent += n;
        end
    endtask

    initial begin
        logic [15:0] cut_set [6];
        bit          mode_set [6];
        int          items_set [6];
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_point_x = '0;
        i_point_y = '0;
        i_point_z = '0;
        i_absorb_value = '0;
        i_emit_value = '0;
        i_last_point = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MODE;
        i_cfg_data = '0;
        idle_on = 1'b1;
        hold_req = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // single point ray, all fields low and all fields high
        send_point(32'h0, 32'h0, 32'h0, 24'h0, 24'h0, 1'b1);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
        // zero-length segment
        send_point(32'h0001_0000, 32'h0, 32'h0, 24'hFFFFFF, 24'h10000, 1'b0);
        send_point(32'h0001_0000, 32'h0, 32'h0, 24'h0, 24'h0, 1'b1);
        // extreme coordinates, full absorption: saturation and full decay
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 24'h1, 24'h1, 1'b1);
        // short segments with modest extinction
        send_point(32'h0, 32'h0, 32'h0, 24'h010000, 24'h004000, 1'b0);
        send_point(32'h0002_0000, 32'h0, 32'h0, 24'h020000, 24'h008000, 1'b0);
        send_point(32'h0002_0000, 32'h0003_0000, 32'h0, 24'h030000, 24'h000100, 1'b0);
        send_point(32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 24'h0, 24'h0, 1'b1);
        drain();

        // linear mode, cutoff max: stop after first segment, then mode change mid ray
        write_reg(CFG_MODE, 16'h0001);
        write_reg(CFG_CUTOFF, 16'hFFFF);
        send_point(32'h0, 32'h0, 32'h0, 24'h010000, 24'h001000, 1'b0);
        send_point(32'h0001_0000, 32'h0, 32'h0, 24'h010000, 24'h001000, 1'b0);
        drain();
        write_reg(CFG_MODE, 16'hFFFE);
        send_point(32'h0002_0000, 32'h0, 32'h0, 24'h010000, 24'h001000, 1'b1);
        drain();
        // mode switch between segments of one ray, cutoff zero
        write_reg(CFG_CUTOFF, 16'h0000);
        send_point(32'h0, 32'h0, 32'h0, 24'h020000, 24'h020000, 1'b0);
        send_point(32'h0000_8000, 32'h0, 32'h0, 24'h020000, 24'h020000, 1'b0);
        drain();
        write_reg(CFG_MODE, 16'h0001);
        send_point(32'h0001_0000, 32'h0, 32'h0, 24'h020000, 24'h030000, 1'b0);
        send_point(32'h0002_0000, 32'h0, 32'h0, 24'h020000, 24'h020000, 1'b1);
        drain();

        mode_set = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
        cut_set = '{16'd655, 16'd655, 16'd0, 16'hFFFF, 16'($urandom), 16'($urandom)};
        items_set = '{300, 350, 300, 150, 350, 350};
        for (int p = 0; p < 6; p++) begin
            drain();
            write_reg(CFG_MODE, {15'($urandom), mode_set[p]});
            write_reg(CFG_CUTOFF, cut_set[p]);
            if (p == 1) begin
                hold_req = 1'b1;
            end
            if (p == 5) begin
                idle_on = 1'b0;
            end
            run_rays(items_set[p]);
        end

        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
